/* rtl/vccc_pkg.sv */
// ----------------------------------------------------------------------------
// vccc_pkg: shared definitions for the vending coin change controller
// Widths, command and event codes, coin table and default configuration.
// ----------------------------------------------------------------------------
package vccc_pkg;

	// default parameter values
	localparam int NUM_PRODUCTS_DEF   = 5;
	localparam int STOCK_CAP_DEF      = 20;
	localparam int BALANCE_LIMIT_DEF  = 500;
	localparam int COIN_COUNT_MAX_DEF = 255;

	// fixed field widths
	localparam int CMD_W     = 3;
	localparam int PIDX_W    = 3;
	localparam int KIND_W    = 2;
	localparam int LOAD_W    = 8;
	localparam int EVENT_W   = 3;
	localparam int COINV_W   = 6;
	localparam int BAL_W     = 9;
	localparam int PRICE_W   = 9;
	localparam int MASK_W    = 5;
	localparam int STOCK_W   = 5;
	localparam int COUNT_W   = 8;
	localparam int REG_IDX_W = 3;

	localparam int NUM_COINS        = 3;
	localparam int NUM_PRICE_REGS   = 5;
	localparam int MAX_CHANGE_COINS = 50;
	localparam int NCNT_W           = 6;

	// reset prices per slot
	localparam logic [PRICE_W-1:0] PRICE_RESET [NUM_PRICE_REGS] =
		'{9'd60, 9'd50, 9'd70, 9'd40, 9'd40};

	// coin kind codes
	localparam logic [KIND_W-1:0] COIN_10   = 2'd0;
	localparam logic [KIND_W-1:0] COIN_20   = 2'd1;
	localparam logic [KIND_W-1:0] COIN_50   = 2'd2;
	localparam logic [KIND_W-1:0] COIN_NONE = 2'd3;

	typedef enum logic [CMD_W-1:0] {
		CMD_COIN       = 3'd0,
		CMD_SELECT     = 3'd1,
		CMD_CHANGE     = 3'd2,
		CMD_LOAD_STOCK = 3'd3,
		CMD_LOAD_COINS = 3'd4
	} cmd_t;

	typedef enum logic [EVENT_W-1:0] {
		EV_STATUS       = 3'd0,
		EV_DISPENSED    = 3'd1,
		EV_REFUSED      = 3'd2,
		EV_COIN_RET     = 3'd3,
		EV_CHANGE_DONE  = 3'd4,
		EV_COIN_REFUSED = 3'd5
	} event_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	// status masks handed from the status logic to the output register
	typedef struct packed {
		logic [MASK_W-1:0] in_stock;
		logic [MASK_W-1:0] can_buy;
	} status_t;

	// value in sen of a coin kind
	function automatic logic [COINV_W-1:0] coin_value(input logic [KIND_W-1:0] kind);
		logic [COINV_W-1:0] v;
		case (kind)
			COIN_10: v = 6'd10;
			COIN_20: v = 6'd20;
			COIN_50: v = 6'd50;
			default: v = 6'd0;
		endcase
		return v;
	endfunction

endpackage

/* rtl/vccc_if.sv */
// ----------------------------------------------------------------------------
// vccc_if: valid/ready channels of the vending coin change controller
// One interface for command items, one for result items.
// ----------------------------------------------------------------------------
interface vccc_cmd_if
	import vccc_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    command;
	logic [PIDX_W-1:0]   product_index;
	logic [KIND_W-1:0]   coin_kind;
	logic [LOAD_W-1:0]   load_count;

	modport source (output valid, command, product_index, coin_kind, load_count,
		input ready);
	modport sink (input valid, command, product_index, coin_kind, load_count,
		output ready);
endinterface

interface vccc_result_if
	import vccc_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [EVENT_W-1:0]  event_kind;
	logic [COINV_W-1:0]  coin_value;
	logic [BAL_W-1:0]    balance;
	logic [MASK_W-1:0]   in_stock_mask;
	logic [MASK_W-1:0]   can_buy_mask;
	logic                last;

	modport source (output valid, event_kind, coin_value, balance, in_stock_mask,
		can_buy_mask, last, input ready);
	modport sink (input valid, event_kind, coin_value, balance, in_stock_mask,
		can_buy_mask, last, output ready);
endinterface

/* rtl/vccc_status.sv */
// ----------------------------------------------------------------------------
// vccc_status: product status masks
// Builds the in-stock and can-buy masks from stock, prices and balance.
// ----------------------------------------------------------------------------
module vccc_status
	import vccc_pkg::*;
#(
	parameter int NUM_PRODUCTS = NUM_PRODUCTS_DEF,
	parameter int NUM_PRICE    = NUM_PRICE_REGS
) (
	input  logic [STOCK_W-1:0] stock [NUM_PRODUCTS],
	input  logic [PRICE_W-1:0] price [NUM_PRICE],
	input  logic [BAL_W-1:0]   balance,
	output status_t            status
);

	// one bit per reported slot; slots past the mask width are not reported
	for (genvar i = 0; i < MASK_W; i++) begin : g_bit
		if (i < NUM_PRICE) begin : g_live
			assign status.in_stock[i] = (stock[i] != '0);
			assign status.can_buy[i]  = (stock[i] != '0) && (balance >= price[i]);
		end else begin : g_none
			assign status.in_stock[i] = 1'b0;
			assign status.can_buy[i]  = 1'b0;
		end
	end

endmodule

/* rtl/vending_coin_change_controller_unit.sv */
// ----------------------------------------------------------------------------
// vending_coin_change_controller_unit: vending controller with coin change
// Keeps stock, coin counts and balance; sells, loads and pays change.
// ----------------------------------------------------------------------------
// Usage:
//   cmd_ch carries command items (insert coin, select, return change, load
//   stock, load coins). It is ready only while no command is in progress.
//   result_ch carries result items; the last item of a command has last set.
//   The user writes prices (wr_en/wr_index/wr_data) only while idle; unenforced.
// Timing:
//   A command is taken, then a shared add/subtract unit runs one step per
//   cycle unless a stall holds it. Each step yields at most one result item.
//   Return change takes one step per returned coin plus one per coin kind it
//   moves past and one for the final item: up to 53 steps. A result passes
//   through the pending stage, then the output register, after its step.
//   The masks are sampled from state after the result's own effect.
// Reset:
//   arst_n clears stock, coin counts, balance and all valid flags; prices
//   return to their default values.
// Stall:
//   A full output register with result_ch.ready low holds the pending item,
//   and the step sequencer waits until it can move.
// ----------------------------------------------------------------------------
module vending_coin_change_controller_unit
	import vccc_pkg::*;
#(
	parameter int NUM_PRODUCTS   = NUM_PRODUCTS_DEF,
	parameter int STOCK_CAP      = STOCK_CAP_DEF,
	parameter int BALANCE_LIMIT  = BALANCE_LIMIT_DEF,
	parameter int COIN_COUNT_MAX = COIN_COUNT_MAX_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	vccc_cmd_if.sink             cmd_ch,
	vccc_result_if.source        result_ch,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [PRICE_W-1:0]   wr_data
);

	localparam int NUM_PRICE = (NUM_PRODUCTS < NUM_PRICE_REGS) ? NUM_PRODUCTS
		: NUM_PRICE_REGS;
	localparam int SIDX_W  = (NUM_PRODUCTS > 1) ? $clog2(NUM_PRODUCTS) : 1;
	localparam int PRIDX_W = (NUM_PRICE > 1) ? $clog2(NUM_PRICE) : 1;

	localparam logic [BAL_W:0]     LIMIT_V     = (BAL_W + 1)'(BALANCE_LIMIT);
	localparam logic [STOCK_W-1:0] STOCK_CAP_V = STOCK_W'(STOCK_CAP);
	localparam logic [COUNT_W-1:0] COIN_MAX_V  = COUNT_W'(COIN_COUNT_MAX);

	// architectural state
	logic [PRICE_W-1:0] price_q    [NUM_PRICE];
	logic [STOCK_W-1:0] stock_q    [NUM_PRODUCTS];
	logic [COUNT_W-1:0] coin_cnt_q [NUM_COINS];
	logic [BAL_W-1:0]   bal_q;

	// sequencer
	state_t             state_q, state_d;
	logic [CMD_W-1:0]   cmd_q;
	logic [PIDX_W-1:0]  prod_q;
	logic [KIND_W-1:0]  kind_q;
	logic [LOAD_W-1:0]  load_q;
	logic [KIND_W-1:0]  sel_q;
	logic [NCNT_W-1:0]  n_q;

	// pending result and output register
	logic               pend_v_q;
	event_t             pend_ev_q;
	logic [COINV_W-1:0] pend_cv_q;
	logic               pend_last_q;
	logic               out_v_q;
	logic [EVENT_W-1:0] out_ev_q;
	logic [COINV_W-1:0] out_cv_q;
	logic [BAL_W-1:0]   out_bal_q;
	status_t            out_stat_q;

	logic               accept, step, step_ok, pend_go;
	logic               prod_ok, price_ok;
	logic [STOCK_W-1:0] stock_rd;
	logic [PRICE_W-1:0] price_rd;
	logic [KIND_W-1:0]  coin_idx;
	logic [COUNT_W-1:0] coin_rd;

	// shared add/subtract unit
	logic [PRICE_W-1:0] alu_b;
	logic               alu_sub;
	logic [BAL_W:0]     alu_res;

	// step decisions
	logic               emit, finish;
	event_t             emit_ev;
	logic [COINV_W-1:0] emit_cv;
	logic               emit_last;
	logic               bal_we, stock_we, coin_we, sel_dec, n_inc;
	logic [STOCK_W-1:0] stock_d;
	logic [COUNT_W-1:0] coin_d;
	logic [STOCK_W-1:0] load_stock;
	logic [COUNT_W-1:0] load_coins;

	status_t            status;

	// handshake
	assign cmd_ch.ready = (state_q == ST_IDLE);
	assign accept       = cmd_ch.valid && cmd_ch.ready;
	assign pend_go      = pend_v_q && (!out_v_q || result_ch.ready);
	assign step_ok      = !pend_v_q || pend_go;
	assign step         = (state_q == ST_RUN) && step_ok;

	// operand reads
	assign prod_ok  = 32'(prod_q) < NUM_PRODUCTS;
	assign price_ok = 32'(prod_q) < NUM_PRICE;
	assign stock_rd = prod_ok ? stock_q[SIDX_W'(prod_q)] : '0;
	assign price_rd = price_ok ? price_q[PRIDX_W'(prod_q)] : '0;
	assign coin_idx = (cmd_t'(cmd_q) == CMD_CHANGE) ? sel_q : kind_q;
	assign coin_rd  = (coin_idx != COIN_NONE) ? coin_cnt_q[coin_idx] : '0;

	assign alu_res = alu_sub ? ({1'b0, bal_q} - {1'b0, alu_b})
		: ({1'b0, bal_q} + {1'b0, alu_b});

	// load clamps
	assign load_stock = (load_q > LOAD_W'(STOCK_CAP)) ? STOCK_CAP_V : load_q[STOCK_W-1:0];
	assign load_coins = (load_q > COIN_MAX_V) ? COIN_MAX_V : load_q;

	// step logic and next state
	always_comb begin
		emit      = 1'b1;
		finish    = 1'b1;
		emit_ev   = EV_STATUS;
		emit_cv   = '0;
		emit_last = 1'b1;
		bal_we    = 1'b0;
		stock_we  = 1'b0;
		coin_we   = 1'b0;
		sel_dec   = 1'b0;
		n_inc     = 1'b0;
		stock_d   = stock_rd;
		coin_d    = coin_rd;
		alu_b     = '0;
		alu_sub   = 1'b0;
		case (cmd_t'(cmd_q))
			CMD_COIN: begin
				alu_b = PRICE_W'(coin_value(kind_q));
				if (kind_q != COIN_NONE && alu_res <= LIMIT_V && coin_rd < COIN_MAX_V) begin
					bal_we  = 1'b1;
					coin_we = 1'b1;
					coin_d  = coin_rd + 1'b1;
				end else begin
					emit_ev = EV_COIN_REFUSED;
				end
			end
			CMD_SELECT: begin
				alu_sub = 1'b1;
				alu_b   = price_rd;
				if (prod_ok && stock_rd != '0 && !alu_res[BAL_W]) begin
					emit_ev  = EV_DISPENSED;
					bal_we   = 1'b1;
					stock_we = 1'b1;
					stock_d  = stock_rd - 1'b1;
				end else begin
					emit_ev = EV_REFUSED;
				end
			end
			CMD_CHANGE: begin
				alu_sub = 1'b1;
				alu_b   = PRICE_W'(coin_value(sel_q));
				if (!alu_res[BAL_W] && coin_rd != '0 && 32'(n_q) < MAX_CHANGE_COINS) begin
					emit_ev   = EV_COIN_RET;
					emit_cv   = coin_value(sel_q);
					emit_last = 1'b0;
					finish    = 1'b0;
					bal_we    = 1'b1;
					coin_we   = 1'b1;
					coin_d    = coin_rd - 1'b1;
					n_inc     = 1'b1;
				end else if (sel_q == COIN_10) begin
					emit_ev = EV_CHANGE_DONE;
				end else begin
					// this coin kind cannot be paid out, try the next smaller one
					emit    = 1'b0;
					finish  = 1'b0;
					sel_dec = 1'b1;
				end
			end
			CMD_LOAD_STOCK: begin
				if (prod_ok) begin
					stock_we = 1'b1;
					stock_d  = load_stock;
				end
			end
			CMD_LOAD_COINS: begin
				if (kind_q != COIN_NONE) begin
					coin_we = 1'b1;
					coin_d  = load_coins;
				end
			end
			default: begin
			end
		endcase

		state_d = state_q;
		case (state_q)
			ST_IDLE: if (accept) state_d = ST_RUN;
			ST_RUN:  if (step && finish) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// command capture and change sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= COIN_50;
			n_q   <= '0;
		end else if (accept) begin
			sel_q <= COIN_50;
			n_q   <= '0;
		end else if (step) begin
			if (sel_dec) sel_q <= sel_q - 1'b1;
			if (n_inc)   n_q   <= n_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= cmd_ch.command;
			prod_q <= cmd_ch.product_index;
			kind_q <= cmd_ch.coin_kind;
			load_q <= cmd_ch.load_count;
		end
	end

	// prices
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PRICE; i++) price_q[i] <= PRICE_RESET[i];
		end else if (wr_en && 32'(wr_index) < NUM_PRICE) begin
			price_q[PRIDX_W'(wr_index)] <= wr_data;
		end
	end

	// balance, stock and coin counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bal_q <= '0;
			for (int i = 0; i < NUM_PRODUCTS; i++) stock_q[i] <= '0;
			for (int i = 0; i < NUM_COINS; i++) coin_cnt_q[i] <= '0;
		end else if (step) begin
			if (bal_we)   bal_q <= alu_res[BAL_W-1:0];
			if (stock_we) stock_q[SIDX_W'(prod_q)] <= stock_d;
			if (coin_we)  coin_cnt_q[coin_idx] <= coin_d;
		end
	end

	// pending result: held in the pending stage so masks see the step's effect
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
		end else if (step && emit) begin
			pend_v_q <= 1'b1;
		end else if (pend_go) begin
			pend_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			pend_ev_q   <= emit_ev;
			pend_cv_q   <= emit_cv;
			pend_last_q <= emit_last;
		end
	end

	// status masks from current state
	vccc_status #(
		.NUM_PRODUCTS (NUM_PRODUCTS),
		.NUM_PRICE    (NUM_PRICE)
	) u_status (
		.stock   (stock_q),
		.price   (price_q),
		.balance (bal_q),
		.status  (status)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (pend_go) begin
			out_v_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_go) begin
			out_ev_q   <= pend_ev_q;
			out_cv_q   <= pend_cv_q;
			out_bal_q  <= bal_q;
			out_stat_q <= status;
			result_ch.last <= pend_last_q;
		end
	end

	assign result_ch.valid         = out_v_q;
	assign result_ch.event_kind    = out_ev_q;
	assign result_ch.coin_value    = out_cv_q;
	assign result_ch.balance       = out_bal_q;
	assign result_ch.in_stock_mask = out_stat_q.in_stock;
	assign result_ch.can_buy_mask  = out_stat_q.can_buy;

endmodule
